// ===== src/msat_pkg.sv =====
// Shared types and constants for the multi-slot alarm timer.
// Holds the request and response beat structs, the slot entry layout, the op codes and the result kinds.
// No dependencies.
package msat_pkg;

   localparam logic [2:0] OP_CREATE   = 3'd0;
   localparam logic [2:0] OP_ARM_ONCE = 3'd1;
   localparam logic [2:0] OP_ARM_PER  = 3'd2;
   localparam logic [2:0] OP_CANCEL   = 3'd3;
   localparam logic [2:0] OP_POLL     = 3'd4;

   localparam logic [1:0] KIND_OK    = 2'd0;
   localparam logic [1:0] KIND_FULL  = 2'd1;
   localparam logic [1:0] KIND_FIRED = 2'd2;

   // A poll reports at most this many fired alarms.
   localparam int MAX_FIRED  = 16;
   localparam int FIRE_CNT_W = 5;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] alarm_id;
      logic [31:0] delay;
      logic [31:0] period;
      logic [15:0] handler_id;
      logic [62:0] now;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] fired_alarm;
      logic [15:0] fired_handler;
      logic [3:0]  slot_index;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] identity;
      logic [63:0] due;
      logic [31:0] interval;
      logic [15:0] handler;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ===== src/multi_slot_alarm_timer_top.sv =====
// Top level of the multi-slot alarm timer: a table of SLOTS alarms kept in one RAM.
// Depends on msat_pkg and msat_ram.
//
// Usage: one request beat on req_* carries an op (create, arm one-shot, arm periodic,
// cancel, poll) and the current time. Every request walks the whole slot table, one
// slot per cycle unless a fired beat waits on rsp_stall, through the RAM's registered
// read port, and modifies entries in place. A poll sends one fired beat on rsp_* for
// each due slot with a nonzero handler, up to MAX_FIRED, while the walk proceeds;
// every request ends with one done beat that has last set. The walk through the single
// read port of the slot RAM sets the request rate, and the block takes no new request
// before the done beat of the current one is loaded.
// req_stall stays high from acceptance until the done beat is loaded.
// Results sit in an output register, so the walk continues while an earlier beat is
// still being taken; it pauses only when a new beat must go out and the register is
// still held by rsp_stall.
// Reset clears all slot valid bits and drops any pending beat; the RAM contents are
// not cleared, since an entry's data is only used when its valid bit is set.
module multi_slot_alarm_timer_top #(
   parameter int SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  msat_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output msat_pkg::rsp_type rsp_data
);

   import msat_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   req_type                req_ff, req_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [SLOTS-1:0]       valid_ff, valid_in;
   logic                   match_found_ff, match_found_in;
   logic [IDX_W-1:0]       match_idx_ff, match_idx_in;
   logic                   free_found_ff, free_found_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;
   logic [FIRE_CNT_W-1:0]  fired_cnt_ff, fired_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   ram_we;
   logic [IDX_W-1:0]       ram_waddr;
   entry_type              ram_wdata;
   logic [IDX_W-1:0]       ram_raddr;
   logic [ENTRY_W-1:0]     ram_rbits;
   entry_type              rd_entry;

   logic                   out_busy;
   logic                   slot_live;
   logic                   id_hit;
   logic                   due_hit;
   logic                   fire;
   logic                   hold;
   logic                   idx_last;
   logic [IDX_W:0]         idx_sum;
   logic                   is_arm;
   logic                   arm_ok;
   logic                   arm_full;
   logic [IDX_W-1:0]       target;

   msat_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(SLOTS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rbits)
   );

   assign rd_entry  = ram_rbits;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The output register can take a new beat unless it is full and stalled.
   assign out_busy  = rsp_valid_ff && rsp_stall;

   assign slot_live = valid_ff[idx_ff];
   assign id_hit    = slot_live && (rd_entry.identity == req_ff.alarm_id);
   assign due_hit   = slot_live && (rd_entry.due <= {1'b0, req_ff.now});
   assign fire      = (req_ff.op == OP_POLL) && due_hit && (rd_entry.handler != 16'd0)
                      && (fired_cnt_ff < FIRE_CNT_W'(MAX_FIRED));
   assign hold      = fire && out_busy;
   assign idx_sum   = {1'b0, idx_ff} + {{IDX_W{1'b0}}, 1'b1};
   assign idx_last  = (idx_ff == IDX_W'(SLOTS - 1));

   assign is_arm    = (req_ff.op == OP_ARM_ONCE) || (req_ff.op == OP_ARM_PER);
   assign arm_ok    = is_arm && (req_ff.alarm_id != 32'd0) && (match_found_ff || free_found_ff);
   assign arm_full  = is_arm && (req_ff.alarm_id != 32'd0) && !match_found_ff && !free_found_ff;
   assign target    = match_found_ff ? match_idx_ff : free_idx_ff;

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      idx_in         = idx_ff;
      valid_in       = valid_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      fired_cnt_in   = fired_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      ram_we         = 1'b0;
      ram_waddr      = idx_ff;
      ram_wdata      = rd_entry;
      ram_raddr      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            // Slot 0 is read while idle so that its data is ready for the first scan cycle.
            if (req_valid) begin
               req_in         = req_data;
               idx_in         = '0;
               match_found_in = 1'b0;
               free_found_in  = 1'b0;
               fired_cnt_in   = '0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hold) begin
               // Re-read the same slot so its data is still there next cycle.
               ram_raddr = idx_ff;
            end else begin
               ram_raddr = idx_last ? '0 : idx_sum[IDX_W-1:0];
               idx_in    = idx_last ? '0 : idx_sum[IDX_W-1:0];
               if (idx_last) begin
                  state_in = ST_DONE;
               end
               priority if ((req_ff.op == OP_CREATE) || (req_ff.op == OP_CANCEL)) begin
                  if (id_hit) begin
                     valid_in[idx_ff] = 1'b0;
                  end
               end else if (is_arm) begin
                  if (id_hit && !match_found_ff) begin
                     match_found_in = 1'b1;
                     match_idx_in   = idx_ff;
                  end
                  if (!slot_live && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = idx_ff;
                  end
               end else if (req_ff.op == OP_POLL) begin
                  if (due_hit) begin
                     if (rd_entry.interval != 32'd0) begin
                        ram_we        = 1'b1;
                        ram_wdata.due = {1'b0, req_ff.now} + {32'd0, rd_entry.interval};
                     end else begin
                        valid_in[idx_ff] = 1'b0;
                     end
                  end
                  if (fire) begin
                     rsp_valid_in              = 1'b1;
                     rsp_data_in.kind          = KIND_FIRED;
                     rsp_data_in.fired_alarm   = rd_entry.identity;
                     rsp_data_in.fired_handler = rd_entry.handler;
                     rsp_data_in.slot_index    = 4'(idx_ff);
                     rsp_data_in.last          = 1'b0;
                     fired_cnt_in              = fired_cnt_ff + FIRE_CNT_W'(1);
                  end
               end else begin
                  // Other op codes change nothing.
                  fired_cnt_in = fired_cnt_ff;
               end
            end
         end
         ST_DONE: begin
            if (!out_busy) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.kind          = arm_full ? KIND_FULL : KIND_OK;
               rsp_data_in.fired_alarm   = 32'd0;
               rsp_data_in.fired_handler = 16'd0;
               rsp_data_in.slot_index    = arm_ok ? 4'(target) : 4'd0;
               rsp_data_in.last          = 1'b1;
               if (arm_ok) begin
                  ram_we             = 1'b1;
                  ram_waddr          = target;
                  ram_wdata.identity = req_ff.alarm_id;
                  ram_wdata.due      = {1'b0, req_ff.now} + {32'd0, req_ff.delay};
                  ram_wdata.interval = (req_ff.op == OP_ARM_PER) ? req_ff.period : 32'd0;
                  ram_wdata.handler  = req_ff.handler_id;
                  valid_in[target]   = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         valid_ff       <= '0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         fired_cnt_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
         idx_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         valid_ff       <= valid_in;
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         fired_cnt_ff   <= fired_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         idx_ff         <= idx_in;
      end
      req_ff       <= req_in;
      match_idx_ff <= match_idx_in;
      free_idx_ff  <= free_idx_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

// ===== src/msat_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the alarm slot table. No dependencies.
module msat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/msat_checker.sv =====
// Port-level checks for the multi-slot alarm timer, bound to the top level.
// Depends on msat_pkg and multi_slot_alarm_timer_top.
module msat_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input msat_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input msat_pkg::rsp_type rsp_data
);

   import msat_pkg::*;

   // A stalled result beat stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(rsp_valid) && $past(rsp_stall))
         |-> (rsp_valid && $stable(rsp_data)))
      else $error("result beat dropped or changed while stalled");

   // The block works on one request at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while another is in progress");

   // Only the closing beat has last set, and it carries no alarm.
   a_beat_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last
         ? (rsp_data.kind != KIND_FIRED && rsp_data.fired_alarm == 32'd0
            && rsp_data.fired_handler == 16'd0)
         : (rsp_data.kind == KIND_FIRED && rsp_data.fired_handler != 16'd0)))
      else $error("malformed result beat");

   // An out-of-slots answer names no slot.
   a_full_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == KIND_FULL) |-> (rsp_data.slot_index == 4'd0))
      else $error("out-of-slots beat carries a slot index");

   // Requests are only taken once the previous closing beat is on its way.
   a_done_before_next: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |-> req_stall)
      else $error("block idle while a fired beat is still pending");

endmodule

bind multi_slot_alarm_timer_top msat_checker u_msat_checker (.*);
